### hdl/crcrd_pkg.sv
package crcrd_pkg;

  // Frame geometry
  localparam int WINDOW_WORDS = 16;
  localparam int WIN_AW = (WINDOW_WORDS > 1) ? $clog2(WINDOW_WORDS) : 1;
  localparam int POS_W = 9;
  localparam logic [POS_W-1:0] PAYLOAD_END = POS_W'(2 + 4 * WINDOW_WORDS);

  // CRC-16/CCITT-FALSE
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_TOP = 16'h8000;

  // Result status codes
  localparam logic [1:0] ST_GOOD = 2'd0;
  localparam logic [1:0] ST_HEADER = 2'd1;
  localparam logic [1:0] ST_CRC = 2'd2;
  localparam logic [1:0] ST_TIMEOUT = 2'd3;

  // Input command codes
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TIMEOUT = 1'b1;

  // Configuration register indexes
  localparam logic REG_HEADER_FIRST = 1'b0;
  localparam logic REG_HEADER_SECOND = 1'b1;

  typedef struct packed {
    logic       command;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] cycle_number;
    logic [5:0]  word_index;
    logic [31:0] word_value;
    logic        last;
  } out_item_t;

  // Control from the sequencer to the CRC unit
  typedef struct packed {
    logic start;
    logic seed;
  } crc_ctl_t;

endpackage

### hdl/crc_checked_request_deframer.sv
// CRC-checked request deframer.
// in channel (in_valid/in_ready/in_data): one transfer per received byte
// or receive timeout. The block hunts two header bytes (registers 0 and 1
// on the cfg channel), then takes a 16-bit cycle number, WINDOW_WORDS
// 32-bit words and a 16-bit CRC, all little-endian. CRC-16/CCITT-FALSE
// covers header, cycle number and payload.
// out channel: on a CRC match, WINDOW_WORDS results (status 0, last set on
// the final one); a header mismatch, CRC mismatch or timeout gives one
// status result with last set.
// A byte that enters the CRC is accepted, then takes eight steps in the
// bit-serial CRC unit, and the block waits to see the unit idle before
// it takes the next byte; the low CRC byte is taken with no such wait.
// in_ready is low while the CRC unit runs and while results are pending.
// A good-frame word goes through a registered window read, then output;
// a status result goes straight to output. A stalled out_ready simply
// holds the result, and the block accepts nothing until the whole run is
// delivered.
// Reset returns to hunting the first header byte with both header
// registers at zero; the window store needs no clearing since a good frame
// rewrites every word before they are sent.
module crc_checked_request_deframer (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  crcrd_pkg::in_item_t    in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output crcrd_pkg::out_item_t   out_data,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic                   cfg_index,
  input  logic [7:0]             cfg_data
);

  typedef enum logic [2:0] {S_IDLE, S_CRC, S_READ, S_OUT} state_t;
  typedef enum logic [1:0] {PH_FIRST, PH_SECOND, PH_BODY} phase_t;

  state_t state;
  phase_t phase;

  logic [7:0] header_first;
  logic [7:0] header_second;
  logic [crcrd_pkg::POS_W-1:0] byte_pos;
  logic [7:0]  crc_low;
  logic [15:0] held_cycle;
  logic [23:0] word_asm;
  logic [crcrd_pkg::WIN_AW-1:0] k;
  logic [1:0]  status;
  logic [31:0] rd_word;

  logic [31:0] window_store [crcrd_pkg::WINDOW_WORDS];

  logic accept;
  logic is_byte;
  logic [7:0] b;
  logic [crcrd_pkg::POS_W-1:0] off;
  logic [1:0] lane;
  logic [crcrd_pkg::WIN_AW-1:0] widx;
  logic body_pay;
  logic mem_we;
  logic last_k;
  crcrd_pkg::crc_ctl_t crc_ctl;
  logic [15:0] crc;
  logic crc_busy;

  assign in_ready = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept = in_valid && in_ready;
  assign is_byte = (in_data.command == crcrd_pkg::CMD_BYTE);
  assign b = in_data.rx_byte;

  // Byte position decode within the payload
  assign off = byte_pos - crcrd_pkg::POS_W'(2);
  assign lane = off[1:0];
  assign widx = off[crcrd_pkg::WIN_AW+1:2];
  assign body_pay = (phase == PH_BODY) && (byte_pos < crcrd_pkg::PAYLOAD_END);
  assign mem_we = accept && is_byte && body_pay && (byte_pos >= crcrd_pkg::POS_W'(2))
                  && (lane == 2'd3);
  assign last_k = (k == crcrd_pkg::WIN_AW'(crcrd_pkg::WINDOW_WORDS - 1));

  // Bytes that go through the CRC
  always_comb begin
    crc_ctl.seed = (phase == PH_FIRST);
    crc_ctl.start = accept && is_byte &&
                    (((phase == PH_FIRST) && (b == header_first)) ||
                     ((phase == PH_SECOND) && (b == header_second)) || body_pay);
  end

  crcrd_crc_unit u_crc (
    .clk  (clk),
    .rst  (rst),
    .ctl  (crc_ctl),
    .data (b),
    .crc  (crc),
    .busy (crc_busy)
  );

  // Window store: one write port, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      window_store[widx] <= {b, word_asm};
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      header_first <= '0;
      header_second <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        crcrd_pkg::REG_HEADER_FIRST: header_first <= cfg_data;
        crcrd_pkg::REG_HEADER_SECOND: header_second <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= PH_FIRST;
      byte_pos <= '0;
      crc_low <= '0;
      held_cycle <= '0;
      word_asm <= '0;
      k <= '0;
      status <= crcrd_pkg::ST_GOOD;
      rd_word <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (!is_byte) begin
              status <= crcrd_pkg::ST_TIMEOUT;
              phase <= PH_FIRST;
              byte_pos <= '0;
              word_asm <= '0;
              crc_low <= '0;
              k <= '0;
              rd_word <= '0;
              out_valid <= 1'b1;
              state <= S_OUT;
            end else begin
              case (phase)
                PH_FIRST, PH_SECOND: begin
                  if ((phase == PH_FIRST) ? (b != header_first) : (b != header_second)) begin
                    status <= crcrd_pkg::ST_HEADER;
                    phase <= PH_FIRST;
                    byte_pos <= '0;
                    word_asm <= '0;
                    crc_low <= '0;
                    k <= '0;
                    rd_word <= '0;
                    out_valid <= 1'b1;
                    state <= S_OUT;
                  end else begin
                    phase <= (phase == PH_FIRST) ? PH_SECOND : PH_BODY;
                    byte_pos <= '0;
                    state <= S_CRC;
                  end
                end
                PH_BODY: begin
                  if (body_pay) begin
                    // cycle number, then word lanes
                    if (byte_pos == '0) begin
                      held_cycle <= {8'h00, b};
                    end else if (byte_pos == crcrd_pkg::POS_W'(1)) begin
                      held_cycle <= {b, held_cycle[7:0]};
                    end else begin
                      case (lane)
                        2'd0: word_asm <= {word_asm[23:8], b};
                        2'd1: word_asm <= {word_asm[23:16], b, word_asm[7:0]};
                        2'd2: word_asm <= {b, word_asm[15:0]};
                        default: word_asm <= '0;
                      endcase
                    end
                    byte_pos <= byte_pos + crcrd_pkg::POS_W'(1);
                    state <= S_CRC;
                  end else if (byte_pos == crcrd_pkg::PAYLOAD_END) begin
                    crc_low <= b;
                    byte_pos <= byte_pos + crcrd_pkg::POS_W'(1);
                  end else begin
                    // final CRC byte: check and start the run
                    phase <= PH_FIRST;
                    byte_pos <= '0;
                    word_asm <= '0;
                    crc_low <= '0;
                    k <= '0;
                    if ({b, crc_low} != crc) begin
                      status <= crcrd_pkg::ST_CRC;
                      rd_word <= '0;
                      out_valid <= 1'b1;
                      state <= S_OUT;
                    end else begin
                      status <= crcrd_pkg::ST_GOOD;
                      state <= S_READ;
                    end
                  end
                end
                default: begin
                  phase <= PH_FIRST;
                  byte_pos <= '0;
                  word_asm <= '0;
                  crc_low <= '0;
                end
              endcase
            end
          end
        end
        S_CRC: begin
          if (!crc_busy) begin
            state <= S_IDLE;
          end
        end
        S_READ: begin
          rd_word <= window_store[k];
          out_valid <= 1'b1;
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if ((status != crcrd_pkg::ST_GOOD) || last_k) begin
              k <= '0;
              state <= S_IDLE;
            end else begin
              k <= k + crcrd_pkg::WIN_AW'(1);
              state <= S_READ;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Result fields
  always_comb begin
    out_data.status = status;
    out_data.cycle_number = (status == crcrd_pkg::ST_GOOD) ? held_cycle : 16'h0000;
    out_data.word_index = 6'(k);
    out_data.word_value = rd_word;
    out_data.last = (status != crcrd_pkg::ST_GOOD) || last_k;
  end

  assert property (@(posedge clk) disable iff (rst) in_ready |-> !out_valid)
    else $error("input taken while a result is pending");

  assert property (@(posedge clk) disable iff (rst)
                   (out_valid && (status != crcrd_pkg::ST_GOOD)) |-> (k == '0))
    else $error("status result with nonzero index");

  assert property (@(posedge clk) disable iff (rst) crc_busy |-> (state == S_CRC))
    else $error("crc running outside its wait state");

  assert property (@(posedge clk) disable iff (rst)
                   (out_valid && out_ready && !out_data.last) |=> (state == S_READ))
    else $error("run stopped before its last word");

endmodule

### hdl/crcrd_crc_unit.sv
module crcrd_crc_unit (
  input  logic              clk,
  input  logic              rst,
  input  crcrd_pkg::crc_ctl_t ctl,
  input  logic [7:0]        data,
  output logic [15:0]       crc,
  output logic              busy
);

  logic [2:0]  bit_cnt;
  logic [15:0] base;

  // seed restarts the accumulator from the init value
  assign base = ctl.seed ? crcrd_pkg::CRC_INIT : crc;

  // One polynomial step per cycle, eight steps per byte
  always_ff @(posedge clk) begin
    if (rst) begin
      crc <= crcrd_pkg::CRC_INIT;
      busy <= 1'b0;
      bit_cnt <= '0;
    end else if (ctl.start) begin
      crc <= base ^ {data, 8'h00};
      busy <= 1'b1;
      bit_cnt <= '0;
    end else if (busy) begin
      if ((crc & crcrd_pkg::CRC_TOP) != 16'h0000) begin
        crc <= {crc[14:0], 1'b0} ^ crcrd_pkg::CRC_POLY;
      end else begin
        crc <= {crc[14:0], 1'b0};
      end
      bit_cnt <= bit_cnt + 3'd1;
      if (bit_cnt == 3'd7) begin
        busy <= 1'b0;
      end
    end
  end

  // A new byte only arrives once the previous one is folded in
  assert property (@(posedge clk) disable iff (rst) ctl.start |-> !busy)
    else $error("crc start while busy");

endmodule
